[sv/rps_pkg.sv]
package rps_pkg;

  localparam int PIX_W   = 16;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLICE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SKIP   = 3'd4;

  localparam int MEAN_W  = 24;
  localparam int STDEV_W = 24;
  localparam int ENT_W   = 62;
  localparam int CNT_W   = 30;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [63:0] LN2_Q64       = 64'hB17217F7D1CF79AB;
  localparam int          LOG_FRAC_BITS = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic               is_total;
    logic               empty_res;
    logic               overflow;
    logic [MEAN_W-1:0]  mean_q8;
    logic [STDEV_W-1:0] stdev_q8;
    logic [ENT_W-1:0]   entropy_sum_q8;
    logic [PIX_W-1:0]   pix_min;
    logic [PIX_W-1:0]   pix_max;
    logic [CNT_W-1:0]   pixel_count;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

endpackage

[sv/rps_front.sv]
module rps_front import rps_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [COORD_W-1:0] in_column,
  input  logic [COORD_W-1:0] in_row,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               q_full,
  output logic               q_wr,
  output item_t              q_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 1);
  localparam logic [DIM_W-1:0] DIM_LIM  = DIM_W'(MAX_DIM);

  logic [COORD_W-1:0] left_r, top_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic               skip_r;
  logic               cfg_wr;
  logic               col_ok, row_ok, zero_ok, keep;
  logic [PIX_W-1:0]   v;
  logic [COORD_W-1:0] col_off, row_off;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= DIM_W'(4096);
      height_r <= DIM_W'(4096);
      skip_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LEFT:   left_r   <= pwdata[COORD_W-1:0];
        REG_TOP:    top_r    <= pwdata[COORD_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_SKIP:   skip_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LEFT:   prdata = DATA_W'(left_r);
      REG_TOP:    prdata = DATA_W'(top_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_SKIP:   prdata = DATA_W'(skip_r);
      default:    prdata = '0;
    endcase
  end

  // region test: offsets only meaningful once the lower bound holds
  assign col_off = in_column - left_r;
  assign row_off = in_row - top_r;
  assign col_ok  = ({1'b0, in_column} < DIM_LIM) && (in_column >= left_r) &&
                   ({1'b0, col_off} < width_r);
  assign row_ok  = ({1'b0, in_row} < DIM_LIM) && (in_row >= top_r) &&
                   ({1'b0, row_off} < height_r);
  assign v       = in_pixel & PIX_MASK;
  assign zero_ok = !(skip_r && (v == '0));

  always_comb begin
    unique case (in_kind)
      KIND_PIXEL:  keep = col_ok && row_ok && zero_ok;
      KIND_SLICE:  keep = 1'b1;
      KIND_VOLUME: keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  // beats that change nothing are taken and dropped here
  assign q_wr         = push && !q_full && keep;
  assign q_item.kind  = in_kind;
  assign q_item.value = v;

endmodule

[sv/rps_queue.sv]
module rps_queue import rps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  item_t wr_item,
  input  logic  rd,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      if (wr && !rd)      cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[sv/rps_mul.sv]
module rps_mul import rps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mul_req_t     req,
  output logic         done,
  output logic [127:0] prod
);

  localparam logic [2:0] LAST = 3'd4;

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [63:0]  p_r;
  logic [1:0]   psh_r;
  logic [2:0]   step_r;
  logic         busy_r, pv_r, done_r;
  logic [31:0]  ah, bh;
  logic [127:0] p_sh;

  // four 32x32 partials, product registered before it is added
  assign ah = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh = step_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (psh_r)
      2'd0:    p_sh = {64'd0, p_r};
      2'd3:    p_sh = {p_r, 64'd0};
      default: p_sh = {32'd0, p_r, 32'd0};
    endcase
  end

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        step_r <= '0;
        pv_r   <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r != LAST) begin
          p_r    <= ah * bh;
          psh_r  <= step_r[1:0];
          pv_r   <= 1'b1;
          step_r <= step_r + 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) begin
          acc_r <= acc_r + p_sh;
          if (step_r == LAST) begin
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

[sv/rps_div.sv]
module rps_div import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot
);

  localparam int IDX_W = $clog2(128);

  logic [127:0]     num_r;
  logic [63:0]      den_r, rem_r, q_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r, done_r;
  logic [63:0]      rb;

  assign rb   = {rem_r[62:0], num_r[127]};
  assign done = done_r;
  assign quot = q_r;

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= '0;
        idx_r  <= '1;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= {num_r[126:0], 1'b0};
        if (rb >= den_r) begin
          rem_r <= rb - den_r;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rb;
          q_r   <= {q_r[62:0], 1'b0};
        end
        if (idx_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

endmodule

[sv/rps_back.sv]
module rps_back import rps_pkg::*; #(
  parameter int MAX_DIM          = 4096,
  parameter int PIXEL_BITS       = 16,
  parameter int TOTAL_COUNT_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  item_t        q_item,
  output logic         q_pop,
  output mul_req_t     mul_req,
  input  logic         mul_done,
  input  logic [127:0] mul_prod,
  output div_req_t     div_req,
  input  logic         div_done,
  input  logic [63:0]  div_quot,
  output result_t      res,
  output logic         res_valid,
  input  logic         res_pop
);

  localparam int SLICE_CAP = MAX_DIM * MAX_DIM;
  localparam int SC_W      = $clog2(SLICE_CAP) + 1;
  localparam int TC_W      = TOTAL_COUNT_BITS;
  localparam int SSUM_W    = PIXEL_BITS + SC_W - 1;
  localparam int TSUM_W    = PIXEL_BITS + TC_W;
  localparam int SSQ_W     = 2 * PIXEL_BITS + SC_W - 1;
  localparam int TSQ_W     = 2 * PIXEL_BITS + TC_W;
  localparam int SENT_W    = PIXEL_BITS + 13 + SC_W - 1;
  localparam int E_W       = $clog2(PIXEL_BITS);
  localparam int K_W       = $clog2(LOG_FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_CAP, S_SQ_W, S_LN_W, S_X_W, S_ACC,
    S_MEAN, S_MEAN_W, S_D_W, S_A_W, S_B_W, S_SD_W,
    S_SQA, S_SQR, S_OUT
  } state_t;

  state_t state_r;

  logic [SSUM_W-1:0] slice_sum_r;
  logic [SSQ_W-1:0]  slice_sq_r;
  logic [SENT_W-1:0] slice_ent_r;
  logic [PIX_W-1:0]  slice_min_r, slice_max_r;
  logic [SC_W-1:0]   slice_cnt_r;
  logic [TSUM_W-1:0] total_sum_r;
  logic [TSQ_W-1:0]  total_sq_r;
  logic [ENT_W-1:0]  total_ent_r;
  logic [PIX_W-1:0]  total_min_r, total_max_r;
  logic [TC_W-1:0]   total_cnt_r;
  logic              dropped_r;

  logic [PIXEL_BITS-1:0] v_r;
  logic [LOG_FRAC_BITS-1:0] frac_r;
  logic [E_W-1:0]        e_r;
  logic [K_W-1:0]        k_r;
  logic [31:0]           t_r;

  logic              is_total_r, ovf_r;
  logic [TSUM_W-1:0] s_sum_r;
  logic [TSQ_W-1:0]  s_sq_r;
  logic [ENT_W-1:0]  s_ent_r;
  logic [PIX_W-1:0]  s_min_r, s_max_r;
  logic [TC_W-1:0]   s_cnt_r;
  logic [MEAN_W-1:0] mean_r;
  logic [STDEV_W-1:0] stdev_r;
  logic [63:0]       d_r;
  logic [127:0]      a_r;
  logic [63:0]       sq_q_r, sq_res_r, sq_bit_r;

  mul_req_t mul_req_r;
  div_req_t div_req_r;
  result_t  res_r;
  logic     res_valid_r;

  logic [E_W-1:0]           e_c;
  logic [63:0]              m_init_c, sq_raw_c, sq_m_c, lg_c, x_c;
  logic                     sq_bit_c;
  logic [LOG_FRAC_BITS-1:0] frac_c;
  logic [PIX_W-1:0]         v16;
  logic [2*PIXEL_BITS-1:0]  vsq_c;
  logic                     cap_hit;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign mul_req   = mul_req_r;
  assign div_req   = div_req_r;
  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign v16       = PIX_W'(v_r);
  assign vsq_c     = {PIXEL_BITS'(0), v_r} * {PIXEL_BITS'(0), v_r};

  always_comb begin
    e_c = '0;
    for (int i = 1; i < PIXEL_BITS; i++) begin
      if (v_r[i]) e_c = E_W'(i);
    end
  end

  // mantissa in Q61, squared each pass to pull out one bit of log2
  assign m_init_c = 64'(v_r) << (6'd61 - 6'(e_c));
  assign sq_raw_c = mul_prod[124:61];
  assign sq_bit_c = (sq_raw_c[63:62] != 2'b00);
  assign sq_m_c   = sq_bit_c ? (sq_raw_c >> 1) : sq_raw_c;
  assign frac_c   = {frac_r[LOG_FRAC_BITS-2:0], sq_bit_c};
  assign lg_c     = (64'(e_r) << LOG_FRAC_BITS) | 64'(frac_c);
  assign x_c      = mul_prod[63:0] + 64'h0000_0000_8000_0000;

  assign cap_hit  = (total_cnt_r == '1) || (slice_cnt_r >= SC_W'(SLICE_CAP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slice_sum_r <= '0;
      slice_sq_r  <= '0;
      slice_ent_r <= '0;
      slice_min_r <= '1;
      slice_max_r <= '0;
      slice_cnt_r <= '0;
      total_sum_r <= '0;
      total_sq_r  <= '0;
      total_ent_r <= '0;
      total_min_r <= '1;
      total_max_r <= '0;
      total_cnt_r <= '0;
      dropped_r   <= 1'b0;
      mul_req_r   <= '0;
      div_req_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      if (res_pop && res_valid_r) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.kind == KIND_PIXEL) begin
              v_r     <= q_item.value[PIXEL_BITS-1:0];
              state_r <= S_CAP;
            end else begin
              is_total_r <= (q_item.kind == KIND_VOLUME);
              ovf_r      <= dropped_r;
              if (q_item.kind == KIND_VOLUME) begin
                s_sum_r     <= total_sum_r;
                s_sq_r      <= total_sq_r;
                s_ent_r     <= total_ent_r;
                s_min_r     <= total_min_r;
                s_max_r     <= total_max_r;
                s_cnt_r     <= total_cnt_r;
                total_sum_r <= '0;
                total_sq_r  <= '0;
                total_ent_r <= '0;
                total_min_r <= '1;
                total_max_r <= '0;
                total_cnt_r <= '0;
                dropped_r   <= 1'b0;
              end else begin
                s_sum_r <= TSUM_W'(slice_sum_r);
                s_sq_r  <= TSQ_W'(slice_sq_r);
                s_ent_r <= ENT_W'(slice_ent_r);
                s_min_r <= slice_min_r;
                s_max_r <= slice_max_r;
                s_cnt_r <= TC_W'(slice_cnt_r);
              end
              slice_sum_r <= '0;
              slice_sq_r  <= '0;
              slice_ent_r <= '0;
              slice_min_r <= '1;
              slice_max_r <= '0;
              slice_cnt_r <= '0;
              state_r     <= S_MEAN;
            end
          end
        end
        S_CAP: begin
          if (cap_hit) begin
            dropped_r <= 1'b1;
            state_r   <= S_IDLE;
          end else if (v_r < PIXEL_BITS'(2)) begin
            t_r     <= '0;
            state_r <= S_ACC;
          end else begin
            e_r       <= e_c;
            frac_r    <= '0;
            k_r       <= '0;
            mul_req_r <= '{start: 1'b1, a: m_init_c, b: m_init_c};
            state_r   <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          if (mul_done) begin
            frac_r <= frac_c;
            if (k_r == K_W'(LOG_FRAC_BITS - 1)) begin
              mul_req_r <= '{start: 1'b1, a: lg_c, b: LN2_Q64};
              state_r   <= S_LN_W;
            end else begin
              k_r       <= k_r + 1'b1;
              mul_req_r <= '{start: 1'b1, a: sq_m_c, b: sq_m_c};
            end
          end
        end
        S_LN_W: begin
          if (mul_done) begin
            mul_req_r <= '{start: 1'b1, a: mul_prod[127:64], b: 64'(v_r)};
            state_r   <= S_X_W;
          end
        end
        S_X_W: begin
          if (mul_done) begin
            t_r     <= x_c[63:32];
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          slice_sum_r <= slice_sum_r + SSUM_W'(v_r);
          total_sum_r <= total_sum_r + TSUM_W'(v_r);
          slice_sq_r  <= slice_sq_r + SSQ_W'(vsq_c);
          total_sq_r  <= total_sq_r + TSQ_W'(vsq_c);
          slice_ent_r <= slice_ent_r + SENT_W'(t_r);
          total_ent_r <= total_ent_r + ENT_W'(t_r);
          if (v16 < slice_min_r) slice_min_r <= v16;
          if (v16 > slice_max_r) slice_max_r <= v16;
          if (v16 < total_min_r) total_min_r <= v16;
          if (v16 > total_max_r) total_max_r <= v16;
          slice_cnt_r <= slice_cnt_r + 1'b1;
          total_cnt_r <= total_cnt_r + 1'b1;
          state_r     <= S_IDLE;
        end
        S_MEAN: begin
          if (s_cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            div_req_r <= '{start: 1'b1, num: 128'({s_sum_r, 8'd0}), den: 64'(s_cnt_r)};
            state_r   <= S_MEAN_W;
          end
        end
        S_MEAN_W: begin
          if (div_done) begin
            mean_r    <= div_quot[MEAN_W-1:0];
            mul_req_r <= '{start: 1'b1, a: 64'(s_cnt_r), b: 64'(s_cnt_r)};
            state_r   <= S_D_W;
          end
        end
        S_D_W: begin
          if (mul_done) begin
            d_r       <= mul_prod[63:0];
            mul_req_r <= '{start: 1'b1, a: 64'(s_cnt_r), b: 64'(s_sq_r)};
            state_r   <= S_A_W;
          end
        end
        S_A_W: begin
          if (mul_done) begin
            a_r       <= mul_prod;
            mul_req_r <= '{start: 1'b1, a: 64'(s_sum_r), b: 64'(s_sum_r)};
            state_r   <= S_B_W;
          end
        end
        S_B_W: begin
          if (mul_done) begin
            if (a_r < mul_prod) begin
              stdev_r <= '0;
              state_r <= S_OUT;
            end else begin
              div_req_r <= '{start: 1'b1, num: (a_r - mul_prod) << 16, den: d_r};
              state_r   <= S_SD_W;
            end
          end
        end
        S_SD_W: begin
          if (div_done) begin
            sq_q_r   <= div_quot;
            sq_res_r <= '0;
            sq_bit_r <= 64'd1 << 62;
            state_r  <= S_SQA;
          end
        end
        S_SQA: begin
          if (sq_bit_r > sq_q_r) sq_bit_r <= sq_bit_r >> 2;
          else                   state_r  <= S_SQR;
        end
        S_SQR: begin
          if (sq_bit_r == '0) begin
            stdev_r <= sq_res_r[STDEV_W-1:0];
            state_r <= S_OUT;
          end else begin
            if (sq_q_r >= sq_res_r + sq_bit_r) begin
              sq_q_r   <= sq_q_r - (sq_res_r + sq_bit_r);
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_OUT: begin
          if (!res_valid_r) begin
            res_valid_r       <= 1'b1;
            res_r.is_total    <= is_total_r;
            res_r.overflow    <= ovf_r;
            res_r.pixel_count <= CNT_W'(s_cnt_r);
            if (s_cnt_r == '0) begin
              res_r.empty_res      <= 1'b1;
              res_r.mean_q8        <= '0;
              res_r.stdev_q8       <= '0;
              res_r.entropy_sum_q8 <= '0;
              res_r.pix_min        <= '0;
              res_r.pix_max        <= '0;
            end else begin
              res_r.empty_res      <= 1'b0;
              res_r.mean_q8        <= mean_r;
              res_r.stdev_q8       <= stdev_r;
              res_r.entropy_sum_q8 <= s_ent_r;
              res_r.pix_min        <= s_min_r;
              res_r.pix_max        <= s_max_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/roi_pixel_statistics.sv]
// Region-of-interest pixel statistics. A pixel beat outside the rectangle,
// a skipped zero or an unknown kind is dropped in the front end and never
// reaches the back end. A counted pixel of value 0 or 1 skips the log2
// step in the back end; any other value runs the 40 serial squarings of
// the log2 loop, each a pass (four 32x32 partial products plus handoff)
// through the one shared multiplier. An end-of-slice or end-of-volume
// beat runs two bit-serial divisions, three multiplies and a square root;
// an empty region skips this arithmetic. A four-entry queue sits between
// front and back, so the input keeps taking beats while the back end
// works, until the queue is full, and one result register decouples the
// output. The user must write the registers only while the block is idle;
// the block itself does not enforce this.
module roi_pixel_statistics import rps_pkg::*; #(
  parameter int MAX_DIM          = 4096,
  parameter int PIXEL_BITS       = 16,
  parameter int TOTAL_COUNT_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [COORD_W-1:0] in_column,
  input  logic [COORD_W-1:0] in_row,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               empty,
  input  logic               pop,
  output logic               out_is_total,
  output logic               out_empty_res,
  output logic               out_overflow,
  output logic [MEAN_W-1:0]  out_mean_q8,
  output logic [STDEV_W-1:0] out_stdev_q8,
  output logic [ENT_W-1:0]   out_entropy_sum_q8,
  output logic [PIX_W-1:0]   out_pix_min,
  output logic [PIX_W-1:0]   out_pix_max,
  output logic [CNT_W-1:0]   out_pixel_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic         q_wr, q_rd, q_full, q_empty;
  item_t        q_wr_item, q_rd_item;
  mul_req_t     mul_req;
  logic         mul_done;
  logic [127:0] mul_prod;
  div_req_t     div_req;
  logic         div_done;
  logic [63:0]  div_quot;
  result_t      res;
  logic         res_valid;

  rps_front #(.MAX_DIM(MAX_DIM), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst_n, .push, .in_kind, .in_column, .in_row, .in_pixel,
    .q_full, .q_wr, .q_item(q_wr_item),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rps_queue u_queue (
    .clk, .rst_n, .wr(q_wr), .wr_item(q_wr_item), .rd(q_rd),
    .rd_item(q_rd_item), .full(q_full), .empty(q_empty)
  );

  rps_mul u_mul (
    .clk, .rst_n, .req(mul_req), .done(mul_done), .prod(mul_prod)
  );

  rps_div u_div (
    .clk, .rst_n, .req(div_req), .done(div_done), .quot(div_quot)
  );

  rps_back #(
    .MAX_DIM(MAX_DIM), .PIXEL_BITS(PIXEL_BITS), .TOTAL_COUNT_BITS(TOTAL_COUNT_BITS)
  ) u_back (
    .clk, .rst_n, .q_empty, .q_item(q_rd_item), .q_pop(q_rd),
    .mul_req, .mul_done, .mul_prod, .div_req, .div_done, .div_quot,
    .res, .res_valid, .res_pop(pop)
  );

  assign full               = q_full;
  assign empty              = !res_valid;
  assign out_is_total       = res.is_total;
  assign out_empty_res      = res.empty_res;
  assign out_overflow       = res.overflow;
  assign out_mean_q8        = res.mean_q8;
  assign out_stdev_q8       = res.stdev_q8;
  assign out_entropy_sum_q8 = res.entropy_sum_q8;
  assign out_pix_min        = res.pix_min;
  assign out_pix_max        = res.pix_max;
  assign out_pixel_count    = res.pixel_count;

endmodule

[sv/rps_checker.sv]
module rps_checker import rps_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic               out_empty_res,
  input logic [MEAN_W-1:0]  out_mean_q8,
  input logic [STDEV_W-1:0] out_stdev_q8,
  input logic [PIX_W-1:0]   out_pix_min,
  input logic [PIX_W-1:0]   out_pix_max,
  input logic [CNT_W-1:0]   out_pixel_count
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_empty_res) |-> (out_mean_q8 == '0 && out_stdev_q8 == '0 &&
      out_pix_min == '0 && out_pix_max == '0 && out_pixel_count == '0))
    else $error("empty result carries nonzero stats");

  // mean must lie between 256*min and 256*max
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_empty_res) |->
      (out_pix_min <= out_pix_max &&
       out_mean_q8 >= {out_pix_min, 8'd0} && out_mean_q8 <= {out_pix_max, 8'd0}))
    else $error("mean outside min/max");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_mean_q8) && $stable(out_pixel_count)))
    else $error("stalled result changed");

endmodule

bind roi_pixel_statistics rps_checker u_rps_checker (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
  .out_empty_res(out_empty_res), .out_mean_q8(out_mean_q8),
  .out_stdev_q8(out_stdev_q8), .out_pix_min(out_pix_min),
  .out_pix_max(out_pix_max), .out_pixel_count(out_pixel_count)
);
